@@ rtl/vnhs_pkg.sv @@
// ----------------------------------------------------------------------------
// vnhs_pkg: shared types and constants of the value noise height sampler
// Widths of the pipeline payloads, the cosine weight table and the hash mix.
// ----------------------------------------------------------------------------
package vnhs_pkg;

	localparam int COORD_BITS  = 24;
	localparam int CELL_BITS   = 3;
	localparam int WGT_W       = 16;
	localparam int LAT_W       = 9;
	localparam int XB_W        = 26;
	localparam int ZB_W        = 42;
	localparam int SC_W        = 55;
	localparam int AMP_W       = 12;
	localparam int HEIGHT_W    = 15;
	localparam int TRUNC_SHIFT = 2 * WGT_W + 6;
	localparam int APB_ADDR_W  = 3;
	localparam int APB_DATA_W  = 32;

	localparam logic [AMP_W-1:0]        AMP_RESET     = 12'd70;
	localparam logic [APB_ADDR_W-3:0]   REG_AMPLITUDE = 1'b0;
	localparam logic [WGT_W:0]          WGT_ONE       = 17'd65536;
	localparam logic signed [LAT_W-1:0] LAT_BIAS      = 9'sd64;

	// (1 - cos(k*pi/8)) / 2 in unsigned Q0.16
	localparam logic [WGT_W-1:0] COS_WEIGHT [8] = '{
		16'd0, 16'd2494, 16'd9598, 16'd20228,
		16'd32768, 16'd45308, 16'd55938, 16'd63042
	};

	typedef struct packed {
		logic [31:0]      cx;
		logic [31:0]      cx1;
		logic [31:0]      cz;
		logic [31:0]      cz1;
		logic [WGT_W-1:0] wx;
		logic [WGT_W-1:0] wz;
	} cell_t;

	typedef struct packed {
		logic [31:0]      mx0;
		logic [31:0]      mx1;
		logic [31:0]      mz0;
		logic [31:0]      mz1;
		logic [WGT_W-1:0] wx;
		logic [WGT_W-1:0] wz;
	} mixed_t;

	typedef struct packed {
		logic [3:0][31:0] h;
		logic [WGT_W-1:0] wx;
		logic [WGT_W-1:0] wz;
	} corner_t;

	typedef struct packed {
		logic signed [XB_W-1:0] i1;
		logic signed [XB_W-1:0] i2;
		logic [WGT_W-1:0]       wz;
	} xblend_t;

	function automatic logic [WGT_W-1:0] weight_of(input logic [CELL_BITS-1:0] frac);
		logic [CELL_BITS+2:0] t;
		// fraction rescaled to a 3-bit table index, up or down
		t = {frac, 3'b000} >> CELL_BITS;
		return COS_WEIGHT[t[2:0]];
	endfunction

	function automatic logic [31:0] mix32(input logic [31:0] v);
		logic [31:0] k;
		k = ~v + (v << 15);
		k = k ^ 32'($signed(k) >>> 12);
		k = k + (k << 2);
		k = k ^ 32'($signed(k) >>> 4);
		k = k << 11;
		k = k ^ 32'($signed(k) >>> 16);
		return k;
	endfunction

	function automatic logic signed [LAT_W-1:0] lattice(input logic [31:0] h);
		logic [31:0]             mag;
		logic signed [LAT_W-1:0] rem;
		// truncating remainder keeps the sign of the hash
		mag = h[31] ? (32'd0 - h) : h;
		rem = $signed({2'b00, mag[6:0]});
		if (h[31]) begin
			rem = -rem;
		end
		return rem - LAT_BIAS;
	endfunction

endpackage

@@ rtl/vnhs_if.sv @@
// ----------------------------------------------------------------------------
// vnhs_if: stream channels of the height sampler
// Coordinate channel in, height channel out, both valid/ready.
// ----------------------------------------------------------------------------
interface vnhs_coord_if;
	logic                                     valid;
	logic                                     ready;
	logic signed [vnhs_pkg::COORD_BITS-1:0]   coord_x;
	logic signed [vnhs_pkg::COORD_BITS-1:0]   coord_z;

	modport source (output valid, output coord_x, output coord_z, input ready);
	modport sink (input valid, input coord_x, input coord_z, output ready);
endinterface

interface vnhs_height_if;
	logic                                   valid;
	logic                                   ready;
	logic signed [vnhs_pkg::HEIGHT_W-1:0]   height;

	modport source (output valid, output height, input ready);
	modport sink (input valid, input height, output ready);
endinterface

@@ rtl/vnhs_apb.sv @@
// ----------------------------------------------------------------------------
// vnhs_apb: configuration register port
// Holds the amplitude register behind a zero wait state APB-style slave.
// ----------------------------------------------------------------------------
module vnhs_apb (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [vnhs_pkg::APB_ADDR_W-1:0]     paddr,
	input  logic [vnhs_pkg::APB_DATA_W-1:0]     pwdata,
	output logic [vnhs_pkg::APB_DATA_W-1:0]     prdata,
	output logic                                pready,
	output logic [vnhs_pkg::AMP_W-1:0]          amplitude
);

	logic [vnhs_pkg::AMP_W-1:0] amplitude_q;
	logic                       hit;

	assign pready    = 1'b1;
	assign hit       = (paddr[vnhs_pkg::APB_ADDR_W-1:2] == vnhs_pkg::REG_AMPLITUDE);
	assign amplitude = amplitude_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			amplitude_q <= vnhs_pkg::AMP_RESET;
		end else if (psel && penable && pwrite && pready && hit) begin
			amplitude_q <= pwdata[vnhs_pkg::AMP_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (hit) begin
			prdata = {{(vnhs_pkg::APB_DATA_W - vnhs_pkg::AMP_W){1'b0}}, amplitude_q};
		end
	end

endmodule

@@ rtl/vnhs_hash.sv @@
// ----------------------------------------------------------------------------
// vnhs_hash: cell split and corner hashing, three stages
// s1 splits the coordinates, s2 mixes the cell indexes, s3 hashes corners.
// ----------------------------------------------------------------------------
module vnhs_hash (
	input  logic              clk,
	input  logic              arst_n,
	vnhs_coord_if.sink        coord,
	output logic              out_valid,
	input  logic              out_ready,
	output vnhs_pkg::corner_t out_data
);

	logic vld_s1, vld_s2, vld_s3;
	logic rdy_s1, rdy_s2, rdy_s3;

	vnhs_pkg::cell_t   cell_s1;
	vnhs_pkg::mixed_t  mix_s2;
	vnhs_pkg::corner_t hash_s3;

	vnhs_pkg::cell_t   cell_d;
	vnhs_pkg::mixed_t  mix_d;
	vnhs_pkg::corner_t hash_d;

	logic [31:0] x32, z32;

	// a stage takes a new transfer when empty or when it empties itself
	assign rdy_s3      = !vld_s3 || out_ready;
	assign rdy_s2      = !vld_s2 || rdy_s3;
	assign rdy_s1      = !vld_s1 || rdy_s2;
	assign coord.ready = rdy_s1;

	always_comb begin
		x32 = {{(32 - vnhs_pkg::COORD_BITS){coord.coord_x[vnhs_pkg::COORD_BITS-1]}},
			coord.coord_x};
		z32 = {{(32 - vnhs_pkg::COORD_BITS){coord.coord_z[vnhs_pkg::COORD_BITS-1]}},
			coord.coord_z};
		cell_d.cx  = 32'($signed(x32) >>> vnhs_pkg::CELL_BITS);
		cell_d.cz  = 32'($signed(z32) >>> vnhs_pkg::CELL_BITS);
		cell_d.cx1 = cell_d.cx + 32'd1;
		cell_d.cz1 = cell_d.cz + 32'd1;
		cell_d.wx  = vnhs_pkg::weight_of(x32[vnhs_pkg::CELL_BITS-1:0]);
		cell_d.wz  = vnhs_pkg::weight_of(z32[vnhs_pkg::CELL_BITS-1:0]);
	end

	always_comb begin
		mix_d.mx0 = vnhs_pkg::mix32(cell_s1.cx);
		mix_d.mx1 = vnhs_pkg::mix32(cell_s1.cx1);
		mix_d.mz0 = vnhs_pkg::mix32(cell_s1.cz);
		mix_d.mz1 = vnhs_pkg::mix32(cell_s1.cz1);
		mix_d.wx  = cell_s1.wx;
		mix_d.wz  = cell_s1.wz;
	end

	// corner order: (x,z) (x+1,z) (x,z+1) (x+1,z+1)
	always_comb begin
		hash_d.h[0] = vnhs_pkg::mix32(mix_s2.mx0 ^ (mix_s2.mz0 << 2));
		hash_d.h[1] = vnhs_pkg::mix32(mix_s2.mx1 ^ (mix_s2.mz0 << 2));
		hash_d.h[2] = vnhs_pkg::mix32(mix_s2.mx0 ^ (mix_s2.mz1 << 2));
		hash_d.h[3] = vnhs_pkg::mix32(mix_s2.mx1 ^ (mix_s2.mz1 << 2));
		hash_d.wx   = mix_s2.wx;
		hash_d.wz   = mix_s2.wz;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			if (rdy_s1) begin
				vld_s1 <= coord.valid;
			end
			if (rdy_s2) begin
				vld_s2 <= vld_s1;
			end
			if (rdy_s3) begin
				vld_s3 <= vld_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && coord.valid) begin
			cell_s1 <= cell_d;
		end
		if (rdy_s2 && vld_s1) begin
			mix_s2 <= mix_d;
		end
		if (rdy_s3 && vld_s2) begin
			hash_s3 <= hash_d;
		end
	end

	assign out_valid = vld_s3;
	assign out_data  = hash_s3;

endmodule

@@ rtl/vnhs_blend.sv @@
// ----------------------------------------------------------------------------
// vnhs_blend: lattice values, cosine blend and scaling, four stages
// s4 blends along x, s5 along z, s6 scales, s7 truncates to the height.
// ----------------------------------------------------------------------------
module vnhs_blend (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  vnhs_pkg::corner_t            in_data,
	input  logic [vnhs_pkg::AMP_W-1:0]   amplitude,
	vnhs_height_if.source                terrain
);

	localparam logic signed [vnhs_pkg::SC_W-1:0] TRUNC_BIAS =
		vnhs_pkg::SC_W'((64'd1 << vnhs_pkg::TRUNC_SHIFT) - 64'd1);

	logic vld_s4, vld_s5, vld_s6, vld_s7;
	logic rdy_s4, rdy_s5, rdy_s6, rdy_s7;

	vnhs_pkg::xblend_t                    xb_s4;
	logic signed [vnhs_pkg::ZB_W-1:0]     zb_s5;
	logic signed [vnhs_pkg::SC_W-1:0]     sc_s6;
	logic signed [vnhs_pkg::HEIGHT_W-1:0] height_s7;

	vnhs_pkg::xblend_t                    xb_d;
	logic signed [vnhs_pkg::ZB_W-1:0]     zb_d;
	logic signed [vnhs_pkg::SC_W-1:0]     sc_d;
	logic signed [vnhs_pkg::SC_W-1:0]     rounded;
	logic signed [vnhs_pkg::HEIGHT_W-1:0] height_d;

	function automatic logic signed [vnhs_pkg::XB_W-1:0] blend_x(
		input logic signed [vnhs_pkg::LAT_W-1:0] a,
		input logic signed [vnhs_pkg::LAT_W-1:0] b,
		input logic [vnhs_pkg::WGT_W-1:0]        w
	);
		logic signed [vnhs_pkg::WGT_W+1:0] wa, wb;
		logic signed [vnhs_pkg::XB_W-1:0]  pa, pb;
		wb = $signed({2'b00, w});
		wa = $signed({1'b0, vnhs_pkg::WGT_ONE - {1'b0, w}});
		pa = a * wa;
		pb = b * wb;
		return pa + pb;
	endfunction

	function automatic logic signed [vnhs_pkg::ZB_W-1:0] blend_z(
		input logic signed [vnhs_pkg::XB_W-1:0] a,
		input logic signed [vnhs_pkg::XB_W-1:0] b,
		input logic [vnhs_pkg::WGT_W-1:0]       w
	);
		logic signed [vnhs_pkg::WGT_W+1:0] wa, wb;
		logic signed [vnhs_pkg::ZB_W-1:0]  pa, pb;
		wb = $signed({2'b00, w});
		wa = $signed({1'b0, vnhs_pkg::WGT_ONE - {1'b0, w}});
		pa = a * wa;
		pb = b * wb;
		return pa + pb;
	endfunction

	assign rdy_s7   = !vld_s7 || terrain.ready;
	assign rdy_s6   = !vld_s6 || rdy_s7;
	assign rdy_s5   = !vld_s5 || rdy_s6;
	assign rdy_s4   = !vld_s4 || rdy_s5;
	assign in_ready = rdy_s4;

	always_comb begin
		xb_d.i1 = blend_x(vnhs_pkg::lattice(in_data.h[0]), vnhs_pkg::lattice(in_data.h[1]),
			in_data.wx);
		xb_d.i2 = blend_x(vnhs_pkg::lattice(in_data.h[2]), vnhs_pkg::lattice(in_data.h[3]),
			in_data.wx);
		xb_d.wz = in_data.wz;
	end

	assign zb_d = blend_z(xb_s4.i1, xb_s4.i2, xb_s4.wz);
	assign sc_d = zb_s5 * $signed({1'b0, amplitude});

	// bias negative values so the arithmetic shift truncates toward zero
	always_comb begin
		rounded  = sc_s6 + (sc_s6[vnhs_pkg::SC_W-1] ? TRUNC_BIAS : '0);
		height_d = vnhs_pkg::HEIGHT_W'(rounded >>> vnhs_pkg::TRUNC_SHIFT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else begin
			if (rdy_s4) begin
				vld_s4 <= in_valid;
			end
			if (rdy_s5) begin
				vld_s5 <= vld_s4;
			end
			if (rdy_s6) begin
				vld_s6 <= vld_s5;
			end
			if (rdy_s7) begin
				vld_s7 <= vld_s6;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s4 && in_valid) begin
			xb_s4 <= xb_d;
		end
		if (rdy_s5 && vld_s4) begin
			zb_s5 <= zb_d;
		end
		if (rdy_s6 && vld_s5) begin
			sc_s6 <= sc_d;
		end
		if (rdy_s7 && vld_s6) begin
			height_s7 <= height_d;
		end
	end

	assign terrain.valid  = vld_s7;
	assign terrain.height = height_s7;

endmodule

@@ rtl/value_noise_height_sampler.sv @@
// ----------------------------------------------------------------------------
// value_noise_height_sampler: 2-D cosine interpolated value noise heights
// Maps a signed grid coordinate to a height, one per clock when not stalled.
// ----------------------------------------------------------------------------
// Usage:
//   coord carries (coord_x, coord_z); terrain returns one height per
//   coordinate, in order. Both channels are valid/ready.
//   The amplitude register sits at byte address 0 of the APB-style port
//   (reset value 70); write it only while no coordinate is in flight.
// Pipeline and throughput:
//   seven register stages, in order: cell split, index mix, corner hash,
//   x blend, z blend, scale, truncate. One coordinate per cycle is taken
//   in steady state while terrain is ready; the rate is set by the
//   pipeline, every stage holding one item.
// Reset:
//   arst_n empties all stages at once and restores the amplitude; no
//   clearing pass, the block is ready as soon as reset is released.
// Stall:
//   when terrain is not ready the last stage holds its result and the
//   stages behind it keep filling bubbles; coord.ready drops only once
//   every stage is occupied.
// ----------------------------------------------------------------------------
module value_noise_height_sampler (
	input  logic                                clk,
	input  logic                                arst_n,
	vnhs_coord_if.sink                          coord,
	vnhs_height_if.source                       terrain,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [vnhs_pkg::APB_ADDR_W-1:0]     paddr,
	input  logic [vnhs_pkg::APB_DATA_W-1:0]     pwdata,
	output logic [vnhs_pkg::APB_DATA_W-1:0]     prdata,
	output logic                                pready
);

	logic [vnhs_pkg::AMP_W-1:0] amplitude;
	logic                       hash_valid;
	logic                       hash_ready;
	vnhs_pkg::corner_t          hash_data;

	vnhs_apb u_apb (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.amplitude (amplitude)
	);

	vnhs_hash u_hash (
		.clk       (clk),
		.arst_n    (arst_n),
		.coord     (coord),
		.out_valid (hash_valid),
		.out_ready (hash_ready),
		.out_data  (hash_data)
	);

	vnhs_blend u_blend (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (hash_valid),
		.in_ready  (hash_ready),
		.in_data   (hash_data),
		.amplitude (amplitude),
		.terrain   (terrain)
	);

`ifndef SYNTHESIS
	// no result leaves while reset is held
	assert property (@(posedge clk) !arst_n |-> !terrain.valid)
		else $error("result valid during reset");

	// an empty output stage means the whole pipeline can take a transfer
	assert property (@(posedge clk) disable iff (!arst_n) !terrain.valid |-> coord.ready)
		else $error("input stalled with empty output stage");

	// amplitude changes only through a register write
	assert property (@(posedge clk) disable iff (!arst_n)
		!(psel && penable && pwrite) |=> $stable(amplitude))
		else $error("amplitude changed without a write");
`endif

endmodule
